FILE: sv/kstl_pkg.sv
// kstl_pkg: shared types, constants and index helpers for the k-mer seed table
package kstl_pkg;

  localparam int HashW         = 20;
  localparam int Buckets       = 2 ** HashW;
  localparam int CountW        = 21;
  localparam int OffsetW       = 32;
  localparam int CharW         = 8;
  localparam int SeedRegW      = 4;
  localparam int SeenW         = 4;
  localparam int MinSeed       = 4;
  localparam int DefMaxSeed    = 10;
  localparam int DefCountBits  = 21;
  localparam int DefSeedLength = 10;
  localparam int SlotsPerWord  = 3;
  localparam int CountWords    = (Buckets + SlotsPerWord - 1) / SlotsPerWord;
  localparam int WordAw        = $clog2(CountWords);
  localparam int SlotW         = 2;
  localparam int DivShift      = HashW + 1;
  localparam int DivRecip      = (2 ** DivShift + SlotsPerWord - 1) / SlotsPerWord;
  localparam int CfgAddrW      = 3;
  localparam int CfgDataW      = 32;

  localparam logic [CfgAddrW-3:0] RegSeedLength = '0;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [CharW-1:0]   base_char;
    logic [HashW-1:0]   bucket_index;
    logic [CountW-1:0]  bucket_count;
    logic [OffsetW-1:0] bucket_offset;
  } in_item_t;

  typedef struct packed {
    logic [HashW-1:0]   hash_value;
    logic               window_full;
    logic [CountW-1:0]  count_out;
    logic [OffsetW-1:0] offset_out;
  } out_item_t;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic             full;
  } win_t;

  typedef struct packed {
    logic              rd_en;
    logic [WordAw-1:0] rd_word;
    logic              wr_en;
    logic [WordAw-1:0] wr_word;
  } cnt_ctrl_t;

  typedef struct packed {
    logic [WordAw-1:0] word;
    logic [SlotW-1:0]  slot;
  } split_t;

  // word = idx / 3 by reciprocal multiply, slot = idx % 3
  function automatic split_t split_index(input logic [HashW-1:0] idx);
    logic [2*HashW-1:0] prod;
    logic [HashW-1:0]   quo;
    logic [HashW-1:0]   rem;
    split_t             res;
    prod = (2*HashW)'(idx) * (2*HashW)'(DivRecip);
    quo  = HashW'(prod[DivShift +: WordAw]);
    rem  = idx - HashW'(quo * HashW'(SlotsPerWord));
    res.word = quo[WordAw-1:0];
    res.slot = rem[SlotW-1:0];
    return res;
  endfunction

endpackage

FILE: sv/kmer_seed_table_lookup_unit.sv
// kmer_seed_table_lookup_unit: top level of the k-mer seed table lookup
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_item_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (out_item_t)
//   cfg      input      apb psel/penable/pready   paddr, pwdata, prdata
//
// one item a cycle sustained unless the output stalls; an accepted item is registered in
// the lookup stage, whose memory read is registered, then in the output register.
// count words are read at accept and, for writes, written back as the item leaves the
// lookup stage; a same-word read at that edge takes the forwarded word.
// reset clears control only; both tables are undefined until written.
// a stalled result holds the lookup stage, which then stalls the input.
module kmer_seed_table_lookup_unit import kstl_pkg::*; #(
  parameter int MAX_SEED   = DefMaxSeed,
  parameter int COUNT_BITS = DefCountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int WordW = SlotsPerWord * COUNT_BITS;

  logic [SeedRegW-1:0] seed_q;
  logic                seed_sel;

  logic                in_accept;
  logic                out_adv;
  win_t                win;
  split_t              split;
  cnt_ctrl_t           cnt_ctrl;
  logic [WordW-1:0]    cnt_rd;
  logic [WordW-1:0]    cnt_wr;
  logic [OffsetW-1:0]  off_rd;

  logic                s1_valid_q;
  op_e                 s1_op_q;
  logic [HashW-1:0]    s1_hash_q;
  logic                s1_full_q;
  split_t              s1_split_q;
  logic [COUNT_BITS-1:0] s1_cnt_q;
  logic [OffsetW-1:0]  s1_off_q;

  logic                out_valid_q;
  out_item_t           out_item_q, out_item_d;
  logic [COUNT_BITS-1:0] slot_val;

  // configuration
  assign pready   = 1'b1;
  assign seed_sel = paddr[CfgAddrW-1:2] == RegSeedLength;
  assign prdata   = seed_sel ? CfgDataW'(seed_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedRegW'(DefSeedLength);
    end else if (psel && penable && pwrite && seed_sel) begin
      seed_q <= pwdata[SeedRegW-1:0];
    end
  end

  // flow control
  assign out_adv    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  kstl_window #(
    .MAX_SEED (MAX_SEED)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .item_i        (in_item_i),
    .seed_length_i (seed_q),
    .win_o         (win)
  );

  assign split = split_index(win.hash);

  always_comb begin
    cnt_ctrl.rd_en   = in_accept;
    cnt_ctrl.rd_word = split.word;
    cnt_ctrl.wr_en   = out_adv && (s1_op_q == OP_WRITE);
    cnt_ctrl.wr_word = s1_split_q.word;
  end

  always_comb begin
    cnt_wr = cnt_rd;
    unique case (s1_split_q.slot)
      2'd0:    cnt_wr[0 +: COUNT_BITS]            = s1_cnt_q;
      2'd1:    cnt_wr[COUNT_BITS +: COUNT_BITS]   = s1_cnt_q;
      2'd2:    cnt_wr[2*COUNT_BITS +: COUNT_BITS] = s1_cnt_q;
      default: cnt_wr = cnt_rd;
    endcase
  end

  kstl_count_store #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cnt_ctrl),
    .wr_data_i (cnt_wr),
    .rd_data_o (cnt_rd)
  );

  kstl_offset_store u_offset_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept && (in_item_i.operation == OP_WRITE)),
    .rd_en_i   (in_accept && (in_item_i.operation != OP_WRITE)),
    .addr_i    (win.hash),
    .wr_data_i (in_item_i.bucket_offset),
    .rd_data_o (off_rd)
  );

  // lookup stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (out_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= in_item_i.operation;
      s1_hash_q  <= win.hash;
      s1_full_q  <= win.full;
      s1_split_q <= split;
      s1_cnt_q   <= in_item_i.bucket_count[COUNT_BITS-1:0];
      s1_off_q   <= in_item_i.bucket_offset;
    end
  end

  always_comb begin
    unique case (s1_split_q.slot)
      2'd0:    slot_val = cnt_rd[0 +: COUNT_BITS];
      2'd1:    slot_val = cnt_rd[COUNT_BITS +: COUNT_BITS];
      2'd2:    slot_val = cnt_rd[2*COUNT_BITS +: COUNT_BITS];
      default: slot_val = '0;
    endcase
  end

  always_comb begin
    out_item_d.hash_value  = s1_hash_q;
    out_item_d.window_full = s1_full_q;
    unique case (s1_op_q)
      OP_WRITE: begin
        out_item_d.count_out  = CountW'(s1_cnt_q);
        out_item_d.offset_out = s1_off_q;
      end
      OP_CLEAR: begin
        out_item_d.count_out  = '0;
        out_item_d.offset_out = '0;
      end
      default: begin
        out_item_d.count_out  = CountW'(slot_val);
        out_item_d.offset_out = off_rd;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: sv/kstl_window.sv
// kstl_window: rolling 2-bit base hash, bases counter and window-full flag
module kstl_window import kstl_pkg::*; #(
  parameter int MAX_SEED = DefMaxSeed
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  in_item_t            item_i,
  input  logic [SeedRegW-1:0] seed_length_i,
  output win_t                win_o
);

  localparam int MaxSeedW = $clog2(MAX_SEED + 1);
  localparam int EffW     = (MaxSeedW > SeedRegW) ? MaxSeedW : SeedRegW;
  localparam int TwiceW   = EffW + 1;

  logic [HashW-1:0] hash_q, hash_d;
  logic [SeenW-1:0] seen_q, seen_d;
  logic [EffW-1:0]  eff_seed;
  logic [EffW-1:0]  seed_ext;
  logic [TwiceW-1:0] twice_seed;
  logic [HashW-1:0] mask;
  logic [1:0]       code;
  logic [HashW-1:0] push_hash;
  logic [SeenW-1:0] push_seen;

  always_comb begin
    unique case (item_i.base_char)
      8'h41, 8'h61: code = 2'd0;
      8'h43, 8'h63: code = 2'd1;
      8'h47, 8'h67: code = 2'd2;
      8'h54, 8'h74: code = 2'd3;
      default:      code = 2'd0;
    endcase
  end

  always_comb begin
    seed_ext = EffW'(seed_length_i);
    if (seed_ext < EffW'(MinSeed)) begin
      eff_seed = EffW'(MinSeed);
    end else if (seed_ext > EffW'(MAX_SEED)) begin
      eff_seed = EffW'(MAX_SEED);
    end else begin
      eff_seed = seed_ext;
    end
    twice_seed = {eff_seed, 1'b0};
    for (int i = 0; i < HashW; i++) begin
      mask[i] = TwiceW'(i) < twice_seed;
    end
  end

  assign push_hash = {hash_q[HashW-3:0], code} & mask;
  assign push_seen = (seen_q == '1) ? seen_q : seen_q + SeenW'(1);

  always_comb begin
    hash_d = hash_q;
    seen_d = seen_q;
    win_o  = '0;
    unique case (item_i.operation)
      OP_PUSH: begin
        hash_d     = push_hash;
        seen_d     = push_seen;
        win_o.hash = push_hash;
        win_o.full = EffW'(push_seen) >= eff_seed;
      end
      OP_WRITE, OP_READ: begin
        win_o.hash = item_i.bucket_index;
        win_o.full = EffW'(seen_q) >= eff_seed;
      end
      OP_CLEAR: begin
        hash_d = '0;
        seen_d = '0;
      end
      default: begin
        win_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      seen_q <= '0;
    end else if (accept_i) begin
      hash_q <= hash_d;
      seen_q <= seen_d;
    end
  end

endmodule

FILE: sv/kstl_count_store.sv
// kstl_count_store: packed count memory with write-to-read forwarding
module kstl_count_store import kstl_pkg::*; #(
  parameter int COUNT_BITS = DefCountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cnt_ctrl_t                      ctrl_i,
  input  logic [SlotsPerWord*COUNT_BITS-1:0] wr_data_i,
  output logic [SlotsPerWord*COUNT_BITS-1:0] rd_data_o
);

  localparam int WordW = SlotsPerWord * COUNT_BITS;

  logic [WordW-1:0] mem [CountWords];
  logic [WordW-1:0] rd_q;
  logic [WordW-1:0] fwd_q;
  logic             hit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_word] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q  <= mem[ctrl_i.rd_word];
      fwd_q <= wr_data_i;
    end
  end

  // a write landing in the same cycle as the read wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      hit_q <= ctrl_i.wr_en && (ctrl_i.wr_word == ctrl_i.rd_word);
    end
  end

  assign rd_data_o = hit_q ? fwd_q : rd_q;

endmodule

FILE: sv/kstl_offset_store.sv
// kstl_offset_store: bucket offset memory, one write or read per cycle
module kstl_offset_store import kstl_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic               rd_en_i,
  input  logic [HashW-1:0]   addr_i,
  input  logic [OffsetW-1:0] wr_data_i,
  output logic [OffsetW-1:0] rd_data_o
);

  logic [OffsetW-1:0] mem [Buckets];
  logic [OffsetW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: dv/kmer_seed_table_lookup_unit_tb.sv
// self-checking testbench for the k-mer seed table lookup unit: directed and random items
module kmer_seed_table_lookup_unit_tb;
  import kstl_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [CountW-1:0] CountMask = CountW'((64'd1 << DefCountBits) - 1);
  localparam logic [HashW-1:0] LastBucket = HashW'(Buckets - 1);

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  kmer_seed_table_lookup_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predicted block state
  logic [SeedRegW-1:0] seed_reg;
  logic [HashW-1:0]    win_hash;
  logic [SeenW-1:0]    seen;
  logic [CountW-1:0]   count_tbl [int];
  logic [OffsetW-1:0]  offset_tbl [int];
  int                  written_idx [$];
  out_item_t           pending_results [$];
  out_item_t           want;

  int errors;
  int cycle_count;
  int n_items, n_push, n_write, n_read, n_clear, n_seeds, n_checked;
  int in_gap_pct;
  int out_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** kmer_seed_table_lookup_unit: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("mismatch %s: got %0h expected %0h", what, got, exp_val);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result hash", 64'(out_item_o.hash_value), 64'd0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_item_o.hash_value !== want.hash_value)
          report_mismatch("hash_value", 64'(out_item_o.hash_value), 64'(want.hash_value));
        if (out_item_o.window_full !== want.window_full)
          report_mismatch("window_full", 64'(out_item_o.window_full),
                          64'(want.window_full));
        if (out_item_o.count_out !== want.count_out)
          report_mismatch("count_out", 64'(out_item_o.count_out), 64'(want.count_out));
        if (out_item_o.offset_out !== want.offset_out)
          report_mismatch("offset_out", 64'(out_item_o.offset_out), 64'(want.offset_out));
      end
    end
  end

  // result side stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
    end
  end

  function automatic int eff_seed();
    int s;
    s = seed_reg;
    if (s < MinSeed) s = MinSeed;
    if (s > DefMaxSeed) s = DefMaxSeed;
    return s;
  endfunction

  function automatic logic [1:0] code_of(logic [CharW-1:0] ch);
    case (ch)
      "A", "a": return 2'd0;
      "C", "c": return 2'd1;
      "G", "g": return 2'd2;
      "T", "t": return 2'd3;
      default:  return 2'd0;
    endcase
  endfunction

  function automatic logic [HashW-1:0] hash_after(logic [CharW-1:0] ch);
    logic [31:0] mask;
    logic [31:0] h;
    mask = (32'd1 << (2 * eff_seed())) - 1;
    h = (({12'd0, win_hash} << 2) | 32'(code_of(ch))) & mask;
    return h[HashW-1:0];
  endfunction

  function automatic logic window_full_now();
    return int'(seen) >= eff_seed();
  endfunction

  task automatic predict_lookup(in_item_t it);
    out_item_t e;
    int        key;
    e = '0;
    n_items++;
    case (it.operation)
      OP_PUSH: begin
        win_hash = hash_after(it.base_char);
        if (seen != '1) seen = seen + SeenW'(1);
        key = int'(win_hash);
        e.hash_value  = win_hash;
        e.window_full = window_full_now();
        e.count_out   = count_tbl[key];
        e.offset_out  = offset_tbl[key];
        n_push++;
      end
      OP_WRITE: begin
        key = int'(it.bucket_index);
        if (!count_tbl.exists(key)) written_idx.insert(written_idx.size(), key);
        count_tbl[key]  = it.bucket_count & CountMask;
        offset_tbl[key] = it.bucket_offset;
        e.hash_value  = it.bucket_index;
        e.window_full = window_full_now();
        e.count_out   = count_tbl[key];
        e.offset_out  = offset_tbl[key];
        n_write++;
      end
      OP_READ: begin
        key = int'(it.bucket_index);
        e.hash_value  = it.bucket_index;
        e.window_full = window_full_now();
        e.count_out   = count_tbl[key];
        e.offset_out  = offset_tbl[key];
        n_read++;
      end
      default: begin
        win_hash = '0;
        seen     = '0;
        n_clear++;
      end
    endcase
    pending_results.insert(pending_results.size(), e);
  endtask

  function automatic in_item_t rand_item(op_e op);
    in_item_t it;
    it.operation     = op;
    it.base_char     = CharW'($urandom);
    it.bucket_index  = HashW'($urandom);
    it.bucket_count  = CountW'($urandom);
    it.bucket_offset = $urandom;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int n;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      n = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    predict_lookup(it);
    in_item_i  = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_bucket(logic [HashW-1:0] idx, logic [CountW-1:0] cnt,
                              logic [OffsetW-1:0] off);
    in_item_t it;
    it = rand_item(OP_WRITE);
    it.bucket_index  = idx;
    it.bucket_count  = cnt;
    it.bucket_offset = off;
    send_item(it);
  endtask

  task automatic read_bucket(logic [HashW-1:0] idx);
    in_item_t it;
    it = rand_item(OP_READ);
    it.bucket_index = idx;
    send_item(it);
  endtask

  task automatic clear_window();
    send_item(rand_item(OP_CLEAR));
  endtask

  // a lookup may only land on a bucket that holds data
  task automatic push_char(logic [CharW-1:0] ch);
    in_item_t         it;
    logic [HashW-1:0] target;
    target = hash_after(ch);
    if (!count_tbl.exists(int'(target)))
      write_bucket(target, CountW'($urandom), $urandom);
    it = rand_item(OP_PUSH);
    it.base_char = ch;
    send_item(it);
  endtask

  function automatic logic [CharW-1:0] random_char();
    string bases;
    bases = "ACGTacgt";
    if ($urandom_range(0, 2) == 0) return CharW'($urandom);
    return bases[$urandom_range(0, 7)];
  endfunction

  task automatic apb_access(input logic wr, input logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {RegSeedLength, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_seed_length(logic [SeedRegW-1:0] v);
    logic [CfgDataW-1:0] rd;
    wait_drained();
    repeat (4) @(posedge clk_i);
    apb_access(1'b1, {28'($urandom), v}, rd);
    seed_reg = v;
    apb_access(1'b0, '0, rd);
    if (rd[SeedRegW-1:0] !== v) report_mismatch("seed_length readback", 64'(rd), 64'(v));
    n_seeds++;
  endtask

  // rewrites a whole count word slot by slot, then reads it back
  task automatic word_neighbours();
    int base;
    int k;
    base = (int'(HashW'($urandom)) / SlotsPerWord) * SlotsPerWord;
    if ($urandom_range(0, 1) == 0 && written_idx.size() != 0)
      base = (written_idx[$urandom_range(0, written_idx.size() - 1)] / SlotsPerWord)
             * SlotsPerWord;
    for (k = 0; k < SlotsPerWord; k++)
      if (base + k < Buckets) write_bucket(HashW'(base + k), CountW'($urandom), $urandom);
    for (k = SlotsPerWord - 1; k >= 0; k--)
      if (base + k < Buckets) read_bucket(HashW'(base + k));
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 5))
      0: write_bucket(HashW'($urandom), CountW'($urandom), $urandom);
      1: write_bucket(HashW'($urandom_range(0, (1 << (2 * eff_seed())) - 1)),
                      CountW'($urandom), $urandom);
      2: read_bucket(HashW'(written_idx[$urandom_range(0, written_idx.size() - 1)]));
      3: word_neighbours();
      4: clear_window();
      default: push_char(random_char());
    endcase
  endtask

  // mostly push runs with random bases, some after a clear, the rest mixed table traffic
  task automatic test_random(int n);
    int stop;
    int run;
    stop = n_items + n;
    while (n_items < stop) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 2) == 0) clear_window();
        run = $urandom_range(1, 24);
        repeat (run) push_char(random_char());
      end else begin
        noise_item();
      end
    end
  endtask

  task automatic test_directed();
    logic [CfgDataW-1:0] rd;
    string               seq;
    int                  i;
    apb_access(1'b0, '0, rd);
    if (rd[SeedRegW-1:0] !== SeedRegW'(DefSeedLength))
      report_mismatch("seed_length after reset", 64'(rd), 64'(DefSeedLength));
    write_bucket('0, '0, '0);
    write_bucket(LastBucket, '1, '1);
    read_bucket('0);
    read_bucket(LastBucket);
    write_bucket(HashW'(3), CountW'(21'h155555), 32'hA5A5_A5A5);
    write_bucket(HashW'(4), CountW'(21'h0AAAAA), 32'h5A5A_5A5A);
    write_bucket(HashW'(5), '1, 32'h0000_0001);
    read_bucket(HashW'(3));
    read_bucket(HashW'(4));
    seq = "ACGTacgtN";
    for (i = 0; i < seq.len(); i++) push_char(seq[i]);
    push_char(8'h00);
    push_char(8'hFF);
    clear_window();
    push_char("T");
    read_bucket(LastBucket);
  endtask

  task automatic test_seed_sweep();
    logic [SeedRegW-1:0] seeds [$];
    seeds = '{4'd4, 4'd0, 4'd15, 4'd10, 4'd3, 4'd11, 4'd5, 4'd9, 4'd7, 4'd6, 4'd8};
    foreach (seeds[i]) begin
      set_seed_length(seeds[i]);
      in_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : 12;
      out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 12;
      test_random(90);
    end
  endtask

  task automatic test_drain_pause();
    in_gap_pct    = 12;
    out_stall_pct = 12;
    test_random(80);
    wait_drained();
    test_random(80);
  endtask

  task automatic test_full_rate();
    logic [HashW-1:0] idx;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    set_seed_length(4'd10);
    repeat (40) begin
      idx = HashW'($urandom);
      write_bucket(idx, CountW'($urandom), $urandom);
      read_bucket(idx);
      word_neighbours();
    end
    test_random(120);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    seed_reg      = SeedRegW'(DefSeedLength);
    win_hash      = '0;
    seen          = '0;
    in_gap_pct    = 10;
    out_stall_pct = 10;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_seed_sweep();
    test_drain_pause();
    test_full_rate();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("ran %0d items (%0d lookups, %0d bucket writes, %0d reads, %0d clears)",
             n_items, n_push, n_write, n_read, n_clear);
    $display("over %0d seed length settings, %0d results compared", n_seeds, n_checked);
    if (errors == 0) begin
      $display("** kmer_seed_table_lookup_unit: PASSED **");
    end else begin
      $display("** kmer_seed_table_lookup_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/kstl_pkg.sv
sv/kstl_window.sv
sv/kstl_count_store.sv
sv/kstl_offset_store.sv
sv/kmer_seed_table_lookup_unit.sv
dv/kmer_seed_table_lookup_unit_tb.sv
